@@ rtl/drr_pkg.sv @@
// Shared constants for the dielectric reflect/refract unit.
// No dependencies; imported by the unit and its checker.
`default_nettype none

package drr_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int INDEX_W             = 15;
    localparam int SCH_FRAC            = 30;
    localparam int REFL_W              = 16;

    localparam logic [INDEX_W-1:0] INDEX_MIN = 15'd8192;
    localparam logic [REFL_W-1:0]  REFL_ONE  = 16'd32768;

endpackage

`default_nettype wire

@@ rtl/dielectric_reflect_refract_unit.sv @@
// Dielectric interface unit: reflection, Snell refraction and Schlick reflectance.
// Depends on drr_pkg.
`default_nettype none

// Usage:
// One input transaction on the s_t* channel carries a normal, a ray direction and the two
// refractive indices. One output transaction on the m_t* channel carries the reflected and
// refracted directions and the reflectance; m_tuser is the total internal reflection flag.
// The unit is a linear pipeline with a valid bit per stage. The index divider retires one
// quotient bit per stage and the square root one result bit per stage, and these two set
// the depth. A new transaction is taken in every cycle while a stage is free, so the
// throughput is one item per clock unless the receiver holds m_tready low.
// Reset clears all valid bits, so the pipeline comes up empty and m_tvalid is low.
// When the receiver holds m_tready low, the output stage holds its transaction and the
// stages behind it keep filling until each holds a transaction; s_tready drops only
// when no stage is free.

module dielectric_reflect_refract_unit
    import drr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // normal_x, normal_y, normal_z, dir_x, dir_y, dir_z, index_incident,
    // index_transmitted, zero padding.
    input  wire logic [((6*COMPONENT_WIDTH+2*INDEX_W+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // reflect_x, reflect_y, reflect_z, refract_x, refract_y, refract_z, reflectance,
    // zero padding.
    output logic [((6*COMPONENT_WIDTH+REFL_W+7)/8)*8-1:0] m_tdata,
    // total_internal.
    output logic [0:0] m_tuser
);

    localparam int W     = COMPONENT_WIDTH;
    localparam int F     = W - 2;
    localparam int SF    = SCH_FRAC;
    localparam int QE    = F + 2;
    localparam int DS    = (QE > SF) ? QE : SF;
    localparam int SQ    = F + 1;
    localparam int EREM  = INDEX_W + QE;
    localparam int RREM  = INDEX_W + 1 + SF;
    localparam int SQW   = 2 * F + 2;
    localparam int MW    = 2 * W + 4;
    localparam int OUT_W = ((6*W+REFL_W+7)/8)*8;

    localparam int ST_PROD = 1;
    localparam int ST_DOT  = 2;
    localparam int ST_RMUL = 3;
    localparam int ST_REFL = 4;
    localparam int ST_DIV0 = 5;
    localparam int ST_E1   = ST_DIV0 + DS;
    localparam int ST_E2   = ST_E1 + 1;
    localparam int ST_E3   = ST_E1 + 2;
    localparam int ST_E4   = ST_E1 + 3;
    localparam int ST_SQ0  = ST_E4 + 1;
    localparam int ST_G1   = ST_SQ0 + SQ;
    localparam int NST     = ST_G1 + 9;

    localparam logic signed [MW-1:0] ONE_M  = MW'(1) <<< F;
    localparam logic signed [MW-1:0] FOUR_M = MW'(1) <<< (F + 2);
    localparam logic signed [MW-1:0] MAX_M  = (MW'(1) <<< (W - 1)) - MW'(1);
    localparam logic signed [MW-1:0] MIN_M  = -(MW'(1) <<< (W - 1));
    localparam logic [SF+1:0] SCH_ONE = (SF+2)'(1) << SF;

    typedef struct packed {
        logic [2:0][W-1:0]     n;
        logic [2:0][W-1:0]     d;
        logic [2:0][W-1:0]     refl;
        logic [2:0][W-1:0]     refr;
        logic [2:0][2*W-1:0]   nd;
        logic [2:0][2*W+1:0]   rn;
        logic [W+1:0]          rd;
        logic [W-1:0]          c;
        logic [INDEX_W-1:0]    n1;
        logic [INDEX_W-1:0]    n2;
        logic [INDEX_W:0]      sum;
        logic                  gt;
        logic [EREM-1:0]       erem;
        logic [QE-1:0]         eta;
        logic [RREM-1:0]       rrem;
        logic [SF-1:0]         r;
        logic [2*QE-1:0]       e2p;
        logic [2*W-1:0]        ccp;
        logic [2*SF-1:0]       r0p;
        logic [2:0][QE+W:0]    etad_p;
        logic [QE+W:0]         etac_p;
        logic [F+3:0]          e2;
        logic [F:0]            s;
        logic [SF-1:0]         r0;
        logic [2:0][W+1:0]     etad;
        logic [W+1:0]          etac;
        logic [2*F+4:0]        st2p;
        logic                  tir;
        logic [SQW-1:0]        sqv;
        logic [SQW-1:0]        sqr;
        logic [W+2:0]          k;
        logic [SF:0]           x1;
        logic [2:0][2*W+2:0]   kn;
        logic [2*SF+1:0]       xp;
        logic [SF:0]           x2;
        logic [SF:0]           x4;
        logic [SF:0]           x5;
        logic [SF:0]           om;
        logic [2*SF+1:0]       tp;
        logic [REFL_W-1:0]     rfl;
    } stage_t;

    function automatic logic signed [MW-1:0] tq(input logic signed [MW-1:0] p);
        logic signed [MW-1:0] mag;
        logic signed [MW-1:0] sh;
        mag = p[MW-1] ? -p : p;
        sh  = mag >>> F;
        return p[MW-1] ? -sh : sh;
    endfunction

    function automatic logic [W-1:0] sat(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] t;
        t = (v > MAX_M) ? MAX_M : ((v < MIN_M) ? MIN_M : v);
        return t[W-1:0];
    endfunction

    stage_t            stg_reg  [NST];
    stage_t            stg_next [NST];
    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    vld_in;
    logic [NST:0]      adv;

    assign adv[NST] = m_tready;
    assign vld_in   = {vld_reg[NST-2:0], s_tvalid};
    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NST-1];

    for (genvar k = 0; k < NST; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_reg
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_comb
    begin
        logic [INDEX_W-1:0] i1;
        logic [INDEX_W-1:0] i2;
        stg_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            stg_next[0].n[i] = s_tdata[i*W +: W];
            stg_next[0].d[i] = s_tdata[(3+i)*W +: W];
        end
        i1 = s_tdata[6*W +: INDEX_W];
        i2 = s_tdata[6*W+INDEX_W +: INDEX_W];
        stg_next[0].n1 = (i1 < INDEX_MIN) ? INDEX_MIN : i1;
        stg_next[0].n2 = (i2 < INDEX_MIN) ? INDEX_MIN : i2;
    end

    for (genvar k = 1; k < NST; k++) begin : g_stage
        if (k == ST_PROD) begin : g_prod
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    stg_next[k].nd[i] = $signed(stg_reg[k-1].n[i])
                                      * $signed(stg_reg[k-1].d[i]);
                end
            end
        end
        else if (k == ST_DOT) begin : g_dot
            always_comb
            begin
                logic signed [MW-1:0] dsum;
                logic signed [MW-1:0] nd_dot;
                logic signed [MW-1:0] rdc;
                logic signed [MW-1:0] cc;
                stg_next[k] = stg_reg[k-1];
                dsum = '0;
                for (int i = 0; i < 3; i++)
                begin
                    dsum = dsum + tq(MW'($signed(stg_reg[k-1].nd[i])));
                end
                nd_dot = -dsum;
                rdc = (dsum > FOUR_M) ? FOUR_M : ((dsum < -FOUR_M) ? -FOUR_M : dsum);
                cc  = (nd_dot > ONE_M) ? ONE_M : ((nd_dot < -ONE_M) ? -ONE_M : nd_dot);
                stg_next[k].rd  = rdc[W+1:0];
                stg_next[k].c   = cc[W-1:0];
                stg_next[k].gt  = stg_reg[k-1].n1 > stg_reg[k-1].n2;
                stg_next[k].sum = (INDEX_W+1)'(stg_reg[k-1].n1)
                                + (INDEX_W+1)'(stg_reg[k-1].n2);
            end
        end
        else if (k == ST_RMUL) begin : g_rmul
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    stg_next[k].rn[i] = $signed(stg_reg[k-1].rd)
                                      * $signed(stg_reg[k-1].n[i]);
                end
            end
        end
        else if (k == ST_REFL) begin : g_refl
            always_comb
            begin
                logic signed [MW-1:0] tr;
                logic [INDEX_W-1:0]   diff;
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    tr = tq(MW'($signed(stg_reg[k-1].rn[i])));
                    stg_next[k].refl[i] = sat(MW'($signed(stg_reg[k-1].d[i])) - (tr <<< 1));
                end
                diff = stg_reg[k-1].gt ? (stg_reg[k-1].n1 - stg_reg[k-1].n2)
                                       : (stg_reg[k-1].n2 - stg_reg[k-1].n1);
                stg_next[k].erem = EREM'(stg_reg[k-1].n1) << F;
                stg_next[k].rrem = RREM'(diff) << SF;
                stg_next[k].eta  = '0;
                stg_next[k].r    = '0;
            end
        end
        else if (k >= ST_DIV0 && k < ST_E1) begin : g_div
            localparam int S   = k - ST_DIV0;
            localparam bit EON = (S < QE);
            localparam bit RON = (S < SF);
            localparam int JE  = EON ? (QE - 1 - S) : 0;
            localparam int JR  = RON ? (SF - 1 - S) : 0;
            always_comb
            begin
                logic [EREM-1:0] te;
                logic [RREM-1:0] tr;
                stg_next[k] = stg_reg[k-1];
                te = EREM'(stg_reg[k-1].n2) << JE;
                tr = RREM'(stg_reg[k-1].sum) << JR;
                if (EON && stg_reg[k-1].erem >= te)
                begin
                    stg_next[k].erem    = stg_reg[k-1].erem - te;
                    stg_next[k].eta[JE] = 1'b1;
                end
                if (RON && stg_reg[k-1].rrem >= tr)
                begin
                    stg_next[k].rrem  = stg_reg[k-1].rrem - tr;
                    stg_next[k].r[JR] = 1'b1;
                end
            end
        end
        else if (k == ST_E1) begin : g_e1
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].e2p = stg_reg[k-1].eta * stg_reg[k-1].eta;
                stg_next[k].ccp = $signed(stg_reg[k-1].c) * $signed(stg_reg[k-1].c);
                stg_next[k].r0p = stg_reg[k-1].r * stg_reg[k-1].r;
                for (int i = 0; i < 3; i++)
                begin
                    stg_next[k].etad_p[i] = $signed({1'b0, stg_reg[k-1].eta})
                                          * $signed(stg_reg[k-1].d[i]);
                end
                stg_next[k].etac_p = $signed({1'b0, stg_reg[k-1].eta})
                                   * $signed(stg_reg[k-1].c);
            end
        end
        else if (k == ST_E2) begin : g_e2
            always_comb
            begin
                logic signed [MW-1:0] sv;
                logic signed [MW-1:0] ev;
                stg_next[k] = stg_reg[k-1];
                stg_next[k].e2 = stg_reg[k-1].e2p[2*QE-1:F];
                sv = ONE_M - tq(MW'($signed(stg_reg[k-1].ccp)));
                stg_next[k].s  = sv[F:0];
                stg_next[k].r0 = stg_reg[k-1].r0p[2*SF-1:SF];
                for (int i = 0; i < 3; i++)
                begin
                    ev = tq(MW'($signed(stg_reg[k-1].etad_p[i])));
                    stg_next[k].etad[i] = ev[W+1:0];
                end
                ev = tq(MW'($signed(stg_reg[k-1].etac_p)));
                stg_next[k].etac = ev[W+1:0];
            end
        end
        else if (k == ST_E3) begin : g_e3
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].st2p = stg_reg[k-1].e2 * stg_reg[k-1].s;
            end
        end
        else if (k == ST_E4) begin : g_e4
            always_comb
            begin
                logic [F+4:0] st2;
                stg_next[k] = stg_reg[k-1];
                st2 = stg_reg[k-1].st2p[2*F+4:F];
                stg_next[k].tir = st2 > ((F+5)'(1) << F);
                stg_next[k].sqv = stg_next[k].tir ? '0
                                : (SQW'(((F+5)'(1) << F) - st2) << F);
                stg_next[k].sqr = '0;
            end
        end
        else if (k >= ST_SQ0 && k < ST_G1) begin : g_sqrt
            localparam int S = k - ST_SQ0;
            localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (F - S));
            always_comb
            begin
                logic [SQW-1:0] t;
                stg_next[k] = stg_reg[k-1];
                t = stg_reg[k-1].sqr + BITV;
                if (stg_reg[k-1].sqv >= t)
                begin
                    stg_next[k].sqv = stg_reg[k-1].sqv - t;
                    stg_next[k].sqr = (stg_reg[k-1].sqr >> 1) + BITV;
                end
                else
                begin
                    stg_next[k].sqr = stg_reg[k-1].sqr >> 1;
                end
            end
        end
        else if (k == ST_G1) begin : g_g1
            always_comb
            begin
                logic [F:0]           cost;
                logic signed [W+1:0]  xv;
                logic signed [W+1:0]  onev;
                stg_next[k] = stg_reg[k-1];
                cost = stg_reg[k-1].sqr[F:0];
                onev = (W+2)'(1) <<< F;
                stg_next[k].k = {stg_reg[k-1].etac[W+1], stg_reg[k-1].etac} - (W+3)'(cost);
                if (stg_reg[k-1].gt)
                begin
                    xv = onev - $signed((W+2)'(cost));
                end
                else
                begin
                    xv = onev - (W+2)'($signed(stg_reg[k-1].c));
                end
                if (xv < 0)
                begin
                    xv = '0;
                end
                else if (xv > onev)
                begin
                    xv = onev;
                end
                stg_next[k].x1 = (SF+1)'(xv[F:0]) << (SF - F);
            end
        end
        else if (k == ST_G1 + 1) begin : g_g2
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    stg_next[k].kn[i] = $signed(stg_reg[k-1].k) * $signed(stg_reg[k-1].n[i]);
                end
                stg_next[k].xp = stg_reg[k-1].x1 * stg_reg[k-1].x1;
            end
        end
        else if (k == ST_G1 + 2) begin : g_g3
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    stg_next[k].refr[i] = stg_reg[k-1].tir ? '0
                        : sat(MW'($signed(stg_reg[k-1].etad[i]))
                              + tq(MW'($signed(stg_reg[k-1].kn[i]))));
                end
                stg_next[k].x2 = stg_reg[k-1].xp[2*SF:SF];
            end
        end
        else if (k == ST_G1 + 3) begin : g_g4
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].xp = stg_reg[k-1].x2 * stg_reg[k-1].x2;
            end
        end
        else if (k == ST_G1 + 4) begin : g_g5
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].x4 = stg_reg[k-1].xp[2*SF:SF];
            end
        end
        else if (k == ST_G1 + 5) begin : g_g6
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].xp = stg_reg[k-1].x4 * stg_reg[k-1].x1;
            end
        end
        else if (k == ST_G1 + 6) begin : g_g7
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].x5 = stg_reg[k-1].xp[2*SF:SF];
                stg_next[k].om = SCH_ONE[SF:0] - (SF+1)'(stg_reg[k-1].r0);
            end
        end
        else if (k == ST_G1 + 7) begin : g_g8
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].tp = stg_reg[k-1].om * stg_reg[k-1].x5;
            end
        end
        else begin : g_g9
            always_comb
            begin
                logic [SF+1:0] res;
                stg_next[k] = stg_reg[k-1];
                res = (SF+2)'(stg_reg[k-1].r0) + (SF+2)'(stg_reg[k-1].tp[2*SF:SF]);
                if (res > SCH_ONE)
                begin
                    res = SCH_ONE;
                end
                stg_next[k].rfl = stg_reg[k-1].tir ? REFL_ONE : res[SF:SF-REFL_W+1];
            end
        end
    end

    assign m_tdata = OUT_W'({stg_reg[NST-1].rfl, stg_reg[NST-1].refr, stg_reg[NST-1].refl});
    assign m_tuser = stg_reg[NST-1].tir;

endmodule

`default_nettype wire

@@ rtl/drr_checker.sv @@
// Port-level checks for the dielectric reflect/refract unit, bound to its top level.
// Depends on drr_pkg and dielectric_reflect_refract_unit.
`default_nettype none

module drr_checker
    import drr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((6*COMPONENT_WIDTH+REFL_W+7)/8)*8-1:0] m_tdata,
    input wire logic [0:0] m_tuser
);

    localparam int W = COMPONENT_WIDTH;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("Output transaction is valid during reset.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output transaction changed.");

    a_tir_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[6*W-1:3*W] == '0 && m_tdata[6*W+REFL_W-1:6*W] == REFL_ONE)
        else $error("Total internal reflection with nonzero refraction or partial reflectance.");

    a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6*W+REFL_W-1:6*W] <= REFL_ONE)
        else $error("Reflectance above one.");

endmodule

bind dielectric_reflect_refract_unit drr_checker #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_drr_checker (.*);

`default_nettype wire

@@ dv/dielectric_reflect_refract_unit_test.sv @@
// Self-checking testbench for the dielectric reflect/refract unit.
// Drives normals, ray directions and indices, predicts every result in fixed point
// and compares it as a whole. Depends on drr_pkg and dielectric_reflect_refract_unit.
`timescale 1ns / 1ps

module dielectric_reflect_refract_unit_test;
    import drr_pkg::*;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int FR = CW - 2;
    localparam longint ONE = longint'(1) << FR;
    localparam int IN_W = ((6*CW+2*INDEX_W+7)/8)*8;
    localparam int OUT_W = ((6*CW+REFL_W+7)/8)*8;
    localparam int LATENCY = 17 + CW + ((CW > 30) ? CW : 30);
    localparam int RANDOM_RAYS = 1500;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [INDEX_W-1:0] n2;
        logic [INDEX_W-1:0] n1;
        logic [CW-1:0] dz;
        logic [CW-1:0] dy;
        logic [CW-1:0] dx;
        logic [CW-1:0] nz;
        logic [CW-1:0] ny;
        logic [CW-1:0] nx;
    } ray_hit_t;

    typedef struct packed {
        logic tir;
        logic [REFL_W-1:0] refl;
        logic [CW-1:0] tz;
        logic [CW-1:0] ty;
        logic [CW-1:0] tx;
        logic [CW-1:0] rz;
        logic [CW-1:0] ry;
        logic [CW-1:0] rx;
    } shade_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    ray_hit_t pending_hits[$];
    shade_t expected_shades[$];
    int mismatches;
    bit stimulus_done;
    bit hold_sender;
    bit in_accepted;
    int burst_left;
    int gap_left;
    int stall_phase;
    longint cycle_count;

    dielectric_reflect_refract_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    function automatic longint fx_mul(longint a, longint b);
        longint ma;
        longint mb;
        longint r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = (ma * mb) >>> FR;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [CW-1:0] to_component(longint v);
        longint c;
        c = clip(v, -(longint'(1) << (CW-1)), (longint'(1) << (CW-1)) - 1);
        return c[CW-1:0];
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic shade_t shade_hit(ray_hit_t h);
        shade_t s;
        longint n[3];
        longint d[3];
        longint unsigned n1;
        longint unsigned n2;
        longint dot;
        longint rd;
        longint c;
        longint eta;
        longint st2;
        longint cos_t;
        longint k;
        longint x;
        longint unsigned x1;
        longint unsigned x2;
        longint unsigned x4;
        longint unsigned x5;
        longint unsigned r;
        longint unsigned r0;
        longint unsigned res;
        longint unsigned sch_one;
        logic [CW-1:0] rv[3];
        logic [CW-1:0] tv[3];
        n[0] = longint'(signed'(h.nx));
        n[1] = longint'(signed'(h.ny));
        n[2] = longint'(signed'(h.nz));
        d[0] = longint'(signed'(h.dx));
        d[1] = longint'(signed'(h.dy));
        d[2] = longint'(signed'(h.dz));
        n1 = longint'((h.n1 < INDEX_MIN) ? INDEX_MIN : h.n1);
        n2 = longint'((h.n2 < INDEX_MIN) ? INDEX_MIN : h.n2);
        dot = fx_mul(n[0], d[0]) + fx_mul(n[1], d[1]) + fx_mul(n[2], d[2]);
        rd = clip(dot, -4*ONE, 4*ONE);
        c = clip(-dot, -ONE, ONE);
        eta = longint'((n1 << FR) / n2);
        st2 = fx_mul(fx_mul(eta, eta), ONE - fx_mul(c, c));
        s.tir = (st2 > ONE);
        cos_t = 0;
        if (!s.tir)
        begin
            cos_t = floor_sqrt(longint'(ONE - st2) << FR);
        end
        k = fx_mul(eta, c) - cos_t;
        for (int i = 0; i < 3; i++)
        begin
            rv[i] = to_component(d[i] - 2*fx_mul(rd, n[i]));
            tv[i] = s.tir ? '0 : to_component(fx_mul(eta, d[i]) + fx_mul(k, n[i]));
        end
        s.rx = rv[0];
        s.ry = rv[1];
        s.rz = rv[2];
        s.tx = tv[0];
        s.ty = tv[1];
        s.tz = tv[2];
        if (s.tir)
            s.refl = REFL_ONE;
        else
        begin
            sch_one = longint'(1) << SCH_FRAC;
            x = clip((n1 > n2) ? ONE - cos_t : ONE - c, 0, ONE);
            x1 = longint'(x) << (SCH_FRAC - FR);
            x2 = (x1 * x1) >> SCH_FRAC;
            x4 = (x2 * x2) >> SCH_FRAC;
            x5 = (x4 * x1) >> SCH_FRAC;
            r = (((n1 > n2) ? n1 - n2 : n2 - n1) << SCH_FRAC) / (n1 + n2);
            r0 = (r * r) >> SCH_FRAC;
            res = r0 + (((sch_one - r0) * x5) >> SCH_FRAC);
            if (res > sch_one)
                res = sch_one;
            s.refl = REFL_W'(res >> (SCH_FRAC - 15));
        end
        return s;
    endfunction

    function automatic ray_hit_t make_hit(longint nx, longint ny, longint nz, longint dx,
                                          longint dy, longint dz, longint n1, longint n2);
        ray_hit_t h;
        h.nx = nx[CW-1:0];
        h.ny = ny[CW-1:0];
        h.nz = nz[CW-1:0];
        h.dx = dx[CW-1:0];
        h.dy = dy[CW-1:0];
        h.dz = dz[CW-1:0];
        h.n1 = n1[INDEX_W-1:0];
        h.n2 = n2[INDEX_W-1:0];
        return h;
    endfunction

    function automatic longint unit_ish();
        return longint'($urandom_range(2*ONE, 0)) - ONE;
    endfunction

    function automatic ray_hit_t random_hit();
        ray_hit_t h;
        int kind;
        int ax;
        int sgn;
        kind = $urandom_range(9);
        h = ray_hit_t'({$urandom, $urandom, $urandom, $urandom});
        if (kind < 6)
        begin
            ax = $urandom_range(2);
            sgn = $urandom_range(1) ? 1 : -1;
            h.nx = (ax == 0) ? CW'(sgn*ONE) : CW'($urandom_range(ONE/4) - ONE/8);
            h.ny = (ax == 1) ? CW'(sgn*ONE) : CW'($urandom_range(ONE/4) - ONE/8);
            h.nz = (ax == 2) ? CW'(sgn*ONE) : CW'($urandom_range(ONE/4) - ONE/8);
            h.dx = CW'(unit_ish());
            h.dy = CW'(unit_ish());
            h.dz = CW'(unit_ish());
            h.n1 = INDEX_W'($urandom_range(20000, 8192));
            h.n2 = INDEX_W'($urandom_range(20000, 8192));
        end
        else if (kind < 8)
        begin
            h.nx = CW'(unit_ish());
            h.ny = CW'(unit_ish());
            h.nz = CW'(unit_ish());
            h.dx = CW'(unit_ish());
            h.dy = CW'(unit_ish());
            h.dz = CW'(unit_ish());
        end
        return h;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        stimulus_done = 1'b0;
        hold_sender = 1'b0;
        pending_hits.push_back(make_hit(0, 0, ONE, 0, 0, -ONE, 8192, 8192));
        pending_hits.push_back(make_hit(0, 0, ONE, 0, 0, -ONE, 8192, 12288));
        pending_hits.push_back(make_hit(0, 0, ONE, ONE/2, 0, -14189, 12288, 8192));
        pending_hits.push_back(make_hit(0, 0, ONE, 14189, 0, -ONE/2, 12288, 8192));
        pending_hits.push_back(make_hit(0, 0, ONE, 14189, 0, -ONE/2, 32767, 8192));
        pending_hits.push_back(make_hit(0, 0, ONE, ONE, 0, 0, 8192, 32767));
        pending_hits.push_back(make_hit(0, 0, ONE, 0, 0, -ONE, 0, 100));
        pending_hits.push_back(make_hit(0, 0, ONE, 0, 0, -ONE, 8191, 32767));
        pending_hits.push_back(make_hit(-32768, -32768, -32768, -32768, -32768, -32768,
                                        32767, 0));
        pending_hits.push_back(make_hit(32767, 32767, 32767, 32767, 32767, 32767,
                                        32767, 32767));
        pending_hits.push_back(make_hit(32767, -32768, 32767, -32768, 32767, -32768,
                                        8192, 16384));
        pending_hits.push_back(make_hit(0, 0, 0, 0, 0, 0, 8192, 8192));
        pending_hits.push_back(make_hit(0, ONE, 0, 0, ONE, 0, 16384, 8192));
        pending_hits.push_back(make_hit(0, ONE, 0, 0, -ONE, 0, 24576, 8192));
        pending_hits.push_back(make_hit(-1, -1, -1, -1, -1, -1, 32767, 8192));
        wait (pending_hits.size() == 0);
        hold_sender = 1'b1;
        wait (expected_shades.size() == 0);
        hold_sender = 1'b0;
        for (int i = 0; i < RANDOM_RAYS; i++)
            pending_hits.push_back(random_hit());
        wait (pending_hits.size() == 0);
        stimulus_done = 1'b1;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || in_accepted)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_hits.size() > 0 && !hold_sender)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= IN_W'(pending_hits.pop_front());
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                m_tready <= 1'b1;
            else if (stall_phase < 60)
                m_tready <= ($urandom_range(3) != 0);
            else
                m_tready <= (stall_phase % 7 < 3) || ($urandom_range(1) == 1);
        end
    end

    always @(posedge clk)
    begin
        shade_t got;
        shade_t want;
        in_accepted <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_shades.push_back(shade_hit(ray_hit_t'(s_tdata[6*CW+2*INDEX_W-1:0])));
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata[6*CW+REFL_W-1:0]};
                if (expected_shades.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected output transaction: %h", got);
                end
                else
                begin
                    want = expected_shades.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected rx %h ry %h rz %h tx %h ty %h tz %h refl %h tir %b, got rx %h ry %h rz %h tx %h ty %h tz %h refl %h tir %b",
                                     want.rx, want.ry, want.rz, want.tx, want.ty, want.tz,
                                     want.refl, want.tir, got.rx, got.ry, got.rz, got.tx,
                                     got.ty, got.tz, got.refl, got.tir);
                    end
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        cycle_count = 0;
        fork
            begin
                wait (stimulus_done);
                wait (expected_shades.size() == 0);
                repeat (LATENCY + 20) @(posedge clk);
                if (mismatches == 0 && expected_shades.size() == 0)
                    $display("SUCCESS");
                else
                    $display("FAILURE");
                $finish;
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                $display("FAILURE");
                $finish;
            end
        join
    end

endmodule

@@ dielectric_reflect_refract_unit.f @@
rtl/drr_pkg.sv
rtl/dielectric_reflect_refract_unit.sv
rtl/drr_checker.sv
dv/dielectric_reflect_refract_unit_test.sv
